// ===== rtl/prim_minimum_spanning_tree_core_defines.svh =====
// Assertion macros for the spanning tree core.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH

// same-cycle implication
`define PMST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmst: same-cycle check failed");

// next-cycle implication
`define PMST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmst: next-cycle check failed");

`endif

// ===== rtl/pmst_pkg.sv =====
// Shared types and constants for the spanning tree core.
// No dependencies.
package pmst_pkg;

  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NUM_NODES_RST   = 32;

  localparam int CFG_W  = 6;
  localparam int NODE_W = 5;
  localparam int EW     = 16;
  localparam int COST_W = 21;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [EW-1:0]     weight;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] parent_node;
    logic [NODE_W-1:0] child_node;
    logic [EW-1:0]     edge_weight;
    logic [COST_W-1:0] total_cost;
    logic              status;
    logic              is_summary;
    logic              last;
  } out_t;

  // control flags from the shared relax/compare unit
  typedef struct packed {
    logic relax;    // link weight beats stored key
    logic take;     // new key beats running minimum
    logic in_tree;  // node membership after this step
  } relax_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_RELAX,
    S_NEXT,
    S_OUT_RD,
    S_OUT_CHK,
    S_SUMMARY
  } state_t;

endpackage

// ===== rtl/prim_minimum_spanning_tree_core.sv =====
// Prim spanning tree core over an adjacency-matrix RAM (upper triangle stored).
// Load word: accepted in IDLE, then read, compare and write back; an ignored load
// skips the read. Run word: at most n tree steps, then the edge words for nodes
// 1..n-1 (stalled while out_ready is low), the summary, then a wipe of the
// MAX_NODES^2-entry matrix; one word at a time, in_ready stays low until done.
// Reset: synchronous; a wipe of all MAX_NODES^2 matrix entries runs before in_ready.
`include "prim_minimum_spanning_tree_core_defines.svh"

module prim_minimum_spanning_tree_core #(
  parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pmst_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pmst_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [pmst_pkg::CFG_W-1:0]  cfg_wdata
);
  import pmst_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int KW  = WEIGHT_BITS + 1;
  localparam int MD  = MAX_NODES * MAX_NODES;
  localparam int AW  = $clog2(MD);
  localparam int NEW = 1 + NW + KW;
  localparam logic [KW-1:0] NO_EDGE = {1'b1, {WEIGHT_BITS{1'b0}}};

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  num_nodes_r;
  logic [CW-1:0]     n_w, n_run_r, n_run_nxt;
  in_t               item_r, item_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]     j_r, j_nxt, picks_r, picks_nxt, oi_r, oi_nxt;
  logic [NW-1:0]     jd_r, jd_nxt, pick_r, pick_nxt, best_idx_r, best_idx_nxt;
  logic              pv_r, pv_nxt, fresh_r, fresh_nxt;
  logic              found_r, found_nxt, broken_r, broken_nxt;
  logic [KW-1:0]     best_r, best_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  // matrix and node RAM ports
  logic              wm_we, wm_re;
  logic [AW-1:0]     wm_waddr, wm_raddr;
  logic [KW-1:0]     wm_wdata, wm_rdata;
  logic              nm_we, nm_re;
  logic [NW-1:0]     nm_waddr, nm_raddr;
  logic [NEW-1:0]    nm_wdata, nm_rdata;

  // node entry fields
  logic [KW-1:0]     nm_key;
  logic [NW-1:0]     nm_par;
  logic              nm_it;

  // load path
  logic [WEIGHT_BITS-1:0] ld_wm;
  logic [KW-1:0]     ld_w;
  logic [NW-1:0]     ld_a, ld_b, ld_lo, ld_hi;
  logic [AW-1:0]     ld_addr;
  logic              ld_ok;

  // relax path
  logic [NW-1:0]     rx_j, rx_lo, rx_hi;
  logic [AW-1:0]     rx_addr;
  logic              rx_is_pick;
  logic              rx_last;

  // shared unit
  logic [KW-1:0]     ux_w, ux_key, ux_key_new;
  logic              ux_in_tree, ux_is_pick;
  relax_ctl_t        ux_ctl;

  pmst_ram #(.DEPTH(MD), .DW(KW)) u_wmem (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .re    (wm_re),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  pmst_ram #(.DEPTH(MAX_NODES), .DW(NEW)) u_nmem (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .re    (nm_re),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  pmst_relax_unit #(.KW(KW)) u_relax (
    .w       (ux_w),
    .key     (ux_key),
    .best    (best_r),
    .in_tree (ux_in_tree),
    .is_pick (ux_is_pick),
    .key_new (ux_key_new),
    .ctl     (ux_ctl)
  );

  // effective node count: 0 acts as 1, clamp to MAX_NODES
  always_comb begin
    if (num_nodes_r == '0) begin
      n_w = CW'(1);
    end else if (num_nodes_r > CFG_W'(MAX_NODES)) begin
      n_w = CW'(MAX_NODES);
    end else begin
      n_w = CW'(num_nodes_r);
    end
  end

  always_comb begin
    nm_key = nm_rdata[KW-1:0];
    nm_par = nm_rdata[KW +: NW];
    nm_it  = nm_rdata[NEW-1];

    ld_wm  = WEIGHT_BITS'(item_r.weight);
    ld_w   = {1'b0, ld_wm};
    ld_a   = NW'(item_r.node_a);
    ld_b   = NW'(item_r.node_b);
    ld_ok  = (item_r.node_a != item_r.node_b) && (ld_wm != '0) &&
             (CFG_W'(item_r.node_a) < CFG_W'(n_w)) &&
             (CFG_W'(item_r.node_b) < CFG_W'(n_w));
    ld_lo  = (ld_a < ld_b) ? ld_a : ld_b;
    ld_hi  = (ld_a < ld_b) ? ld_b : ld_a;
    ld_addr = AW'(AW'(ld_lo) * AW'(MAX_NODES) + AW'(ld_hi));

    rx_j    = NW'(j_r);
    rx_lo   = (pick_r < rx_j) ? pick_r : rx_j;
    rx_hi   = (pick_r < rx_j) ? rx_j : pick_r;
    rx_addr = AW'(AW'(rx_lo) * AW'(MAX_NODES) + AW'(rx_hi));
    rx_is_pick = (jd_r == pick_r);
    rx_last    = (CW'(jd_r) == n_run_r - CW'(1));
  end

  // operand select for the shared unit
  always_comb begin
    if (state_r == S_RELAX) begin
      ux_w       = wm_rdata;
      ux_key     = fresh_r ? NO_EDGE : nm_key;
      ux_in_tree = fresh_r ? 1'b0 : nm_it;
      ux_is_pick = rx_is_pick;
    end else begin
      ux_w       = ld_w;
      ux_key     = wm_rdata;
      ux_in_tree = 1'b0;
      ux_is_pick = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    n_run_nxt     = n_run_r;
    item_nxt      = item_r;
    clr_addr_nxt  = clr_addr_r;
    j_nxt         = j_r;
    picks_nxt     = picks_r;
    oi_nxt        = oi_r;
    jd_nxt        = jd_r;
    pick_nxt      = pick_r;
    best_idx_nxt  = best_idx_r;
    pv_nxt        = pv_r;
    fresh_nxt     = fresh_r;
    found_nxt     = found_r;
    broken_nxt    = broken_r;
    best_nxt      = best_r;
    cost_nxt      = cost_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;

    wm_we    = 1'b0;
    wm_waddr = ld_addr;
    wm_wdata = ld_w;
    wm_re    = 1'b0;
    wm_raddr = ld_addr;
    nm_we    = 1'b0;
    nm_waddr = jd_r;
    nm_wdata = {ux_ctl.in_tree,
                (ux_ctl.relax ? pick_r : (fresh_r ? {NW{1'b0}} : nm_par)),
                ux_key_new};
    nm_re    = 1'b0;
    nm_raddr = rx_j;

    case (state_r)
      S_CLEAR: begin
        wm_we    = 1'b1;
        wm_waddr = clr_addr_r;
        wm_wdata = NO_EDGE;
        if (clr_addr_r == AW'(MD - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          n_run_nxt = n_w;
          if (in_data.operation == OP_LOAD) begin
            state_nxt = S_LOAD_RD;
          end else begin
            // first pass grows from node 0 and initializes every key
            state_nxt  = S_RELAX;
            pick_nxt   = '0;
            fresh_nxt  = 1'b1;
            picks_nxt  = '0;
            j_nxt      = '0;
            pv_nxt     = 1'b0;
            best_nxt   = NO_EDGE;
            found_nxt  = 1'b0;
            broken_nxt = 1'b0;
            cost_nxt   = '0;
          end
        end
      end
      S_LOAD_RD: begin
        if (ld_ok) begin
          wm_re     = 1'b1;
          state_nxt = S_LOAD_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD_WR: begin
        wm_we     = ux_ctl.relax;
        state_nxt = S_IDLE;
      end
      S_RELAX: begin
        // issue stage
        if (j_r < n_run_r) begin
          wm_re    = 1'b1;
          wm_raddr = rx_addr;
          nm_re    = 1'b1;
          j_nxt    = j_r + CW'(1);
          pv_nxt   = 1'b1;
          jd_nxt   = rx_j;
        end else begin
          pv_nxt = 1'b0;
        end
        // process stage: relax node jd_r and track next pick
        if (pv_r) begin
          nm_we = 1'b1;
          if (ux_ctl.take) begin
            best_nxt     = ux_key_new;
            best_idx_nxt = jd_r;
            found_nxt    = 1'b1;
          end
          if (rx_last) begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (picks_r + CW'(1) == n_run_r) begin
          state_nxt = S_OUT_RD;
          oi_nxt    = CW'(1);
        end else if (!found_r) begin
          broken_nxt = 1'b1;
          state_nxt  = S_OUT_RD;
          oi_nxt     = CW'(1);
        end else begin
          pick_nxt  = best_idx_r;
          fresh_nxt = 1'b0;
          picks_nxt = picks_r + CW'(1);
          j_nxt     = '0;
          best_nxt  = NO_EDGE;
          found_nxt = 1'b0;
          state_nxt = S_RELAX;
        end
      end
      S_OUT_RD: begin
        if (oi_r >= n_run_r) begin
          state_nxt = S_SUMMARY;
        end else begin
          nm_re     = 1'b1;
          nm_raddr  = NW'(oi_r);
          state_nxt = S_OUT_CHK;
        end
      end
      S_OUT_CHK: begin
        if (!nm_it) begin
          oi_nxt    = oi_r + CW'(1);
          state_nxt = S_OUT_RD;
        end else if (out_free) begin
          out_nxt.parent_node = NODE_W'(nm_par);
          out_nxt.child_node  = NODE_W'(oi_r);
          out_nxt.edge_weight = EW'(nm_key);
          out_nxt.total_cost  = '0;
          out_nxt.status      = 1'b0;
          out_nxt.is_summary  = 1'b0;
          out_nxt.last        = 1'b0;
          out_valid_nxt       = 1'b1;
          cost_nxt            = cost_r + COST_W'(nm_key);
          oi_nxt              = oi_r + CW'(1);
          state_nxt           = S_OUT_RD;
        end
      end
      S_SUMMARY: begin
        if (out_free) begin
          out_nxt.parent_node = '0;
          out_nxt.child_node  = '0;
          out_nxt.edge_weight = '0;
          out_nxt.total_cost  = cost_r;
          out_nxt.status      = broken_r;
          out_nxt.is_summary  = 1'b1;
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
          clr_addr_nxt        = '0;
          state_nxt           = S_CLEAR;
        end
      end
      default: begin
        clr_addr_nxt = '0;
        state_nxt    = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      num_nodes_r <= CFG_W'(NUM_NODES_RST);
      n_run_r     <= CW'(1);
      clr_addr_r  <= '0;
      j_r         <= '0;
      picks_r     <= '0;
      oi_r        <= '0;
      jd_r        <= '0;
      pick_r      <= '0;
      best_idx_r  <= '0;
      pv_r        <= 1'b0;
      fresh_r     <= 1'b0;
      found_r     <= 1'b0;
      broken_r    <= 1'b0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        num_nodes_r <= cfg_wdata;
      end
      n_run_r     <= n_run_nxt;
      clr_addr_r  <= clr_addr_nxt;
      j_r         <= j_nxt;
      picks_r     <= picks_nxt;
      oi_r        <= oi_nxt;
      jd_r        <= jd_nxt;
      pick_r      <= pick_nxt;
      best_idx_r  <= best_idx_nxt;
      pv_r        <= pv_nxt;
      fresh_r     <= fresh_nxt;
      found_r     <= found_nxt;
      broken_r    <= broken_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    best_r <= best_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PMST_ASSERT_NOW(a_proc_idx_in_range, pv_r, CW'(jd_r) < n_run_r)
  `PMST_ASSERT_NOW(a_picks_below_n, state_r == S_NEXT, picks_r < n_run_r)
  `PMST_ASSERT_NOW(a_found_has_link, found_r, best_r != NO_EDGE)
  `PMST_ASSERT_NOW(a_edge_word_shape, out_valid_r && !out_r.is_summary,
                   out_r.child_node != '0 && !out_r.last && !out_r.status)
  `PMST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== rtl/pmst_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pmst_ram #(
  parameter int DEPTH = 32,
  parameter int DW    = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pmst_relax_unit.sv =====
// Shared compare unit: key relaxation plus running-minimum compare.
// Depends on pmst_pkg.
module pmst_relax_unit #(
  parameter int KW = 17
) (
  input  logic [KW-1:0]          w,
  input  logic [KW-1:0]          key,
  input  logic [KW-1:0]          best,
  input  logic                   in_tree,
  input  logic                   is_pick,
  output logic [KW-1:0]          key_new,
  output pmst_pkg::relax_ctl_t   ctl
);
  import pmst_pkg::*;

  logic open_node;

  always_comb begin
    open_node   = !in_tree && !is_pick;
    ctl.relax   = open_node && (w < key);
    key_new     = ctl.relax ? w : key;
    ctl.take    = open_node && (key_new < best);
    ctl.in_tree = in_tree || is_pick;
  end

endmodule

// ===== bench/prim_minimum_spanning_tree_core_tb.sv =====
// Testbench for prim_minimum_spanning_tree_core: directed table, then random graphs.
// Tree words are checked against an in-bench Prim predictor of the matrix, or literal summaries.
// Depends on pmst_pkg and the core RTL only.
module prim_minimum_spanning_tree_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmst_pkg::*;

  localparam int MAXN        = MAX_NODES_DEF;
  localparam int IDLE_WAIT   = MAXN * MAXN + 64;  // matrix wipe plus margin
  localparam int ITEM_TARGET = 200;
  localparam int HOLD_CYCLES = 300;
  localparam logic ST_SPANNED = 1'b0;
  localparam logic ST_SPLIT   = 1'b1;
  localparam logic [EW:0] NO_LINK = {1'b1, {EW{1'b0}}};

  typedef struct {
    bit               set_cfg;
    logic [CFG_W-1:0] cfg_val;
    in_t              word;
    bit               lit;
    out_t             want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic [EW:0]      adj [MAXN][MAXN];
  logic [CFG_W-1:0] nodes_cfg;
  out_t             step_res [MAXN+1];
  out_t             tree_expect [$];

  int err_cnt;
  bit tx_fast;
  bit hold_req;
  bit held;

  prim_minimum_spanning_tree_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #(50_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] exp);
    if (got !== exp) begin
      log_mismatch($sformatf("%s got %0h exp %0h", name, got, exp));
    end
  endtask

  function automatic int eff_nodes(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAXN) return MAXN;
    return int'(v);
  endfunction

  // Apply one word to the matrix model; a run fills step_res and returns the count.
  function automatic int mst_step(input in_t w);
    int n, i, j, pick, cnt, step;
    logic [EW:0] key [MAXN];
    logic [NODE_W-1:0] par [MAXN];
    bit joined [MAXN];
    bit split;
    logic [EW:0] best;
    logic [COST_W-1:0] cost;
    n = eff_nodes(nodes_cfg);
    if (w.operation == OP_LOAD) begin
      if (w.node_a != w.node_b && w.weight != 0 && w.node_a < n && w.node_b < n &&
          {1'b0, w.weight} < adj[w.node_a][w.node_b]) begin
        adj[w.node_a][w.node_b] = {1'b0, w.weight};
        adj[w.node_b][w.node_a] = {1'b0, w.weight};
      end
      return 0;
    end
    for (i = 0; i < MAXN; i++) begin
      key[i] = NO_LINK;
      par[i] = '0;
      joined[i] = 1'b0;
    end
    key[0] = '0;
    split = 1'b0;
    for (step = 0; step < n && !split; step++) begin
      best = NO_LINK;
      pick = n;
      // lowest index wins ties
      for (i = 0; i < n; i++) begin
        if (!joined[i] && key[i] < best) begin
          best = key[i];
          pick = i;
        end
      end
      if (pick >= n) begin
        split = 1'b1;
      end else begin
        joined[pick] = 1'b1;
        for (j = 0; j < n; j++) begin
          if (!joined[j] && adj[pick][j] < key[j]) begin
            par[j] = NODE_W'(pick);
            key[j] = adj[pick][j];
          end
        end
      end
    end
    cost = '0;
    cnt = 0;
    for (i = 1; i < n; i++) begin
      if (joined[i]) begin
        cost = cost + COST_W'(key[i][EW-1:0]);
        step_res[cnt] = '{par[i], NODE_W'(i), key[i][EW-1:0], '0, ST_SPANNED, 1'b0, 1'b0};
        cnt++;
      end
    end
    step_res[cnt] = '{'0, '0, '0, cost, split ? ST_SPLIT : ST_SPANNED, 1'b1, 1'b1};
    cnt++;
    for (i = 0; i < MAXN; i++) begin
      for (j = 0; j < MAXN; j++) begin
        adj[i][j] = NO_LINK;
      end
    end
    return cnt;
  endfunction

  function automatic in_t load_word(input int a, input int b, input logic [EW-1:0] wt);
    in_t w;
    w.operation = OP_LOAD;
    if ($urandom_range(0, 1)) begin
      w.node_a = NODE_W'(a);
      w.node_b = NODE_W'(b);
    end else begin
      w.node_a = NODE_W'(b);
      w.node_b = NODE_W'(a);
    end
    w.weight = wt;
    return w;
  endfunction

  function automatic logic [EW-1:0] rand_weight();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return EW'($urandom_range(1, 4));  // ties and parallel edges
    if (sel == 4) return {EW{1'b1}};
    return EW'($urandom_range(1, 65535));
  endfunction

  function automatic in_t run_word();
    in_t w;
    w.operation = OP_RUN;
    w.node_a = NODE_W'($urandom_range(0, 31));
    w.node_b = NODE_W'($urandom_range(0, 31));
    w.weight = EW'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic dir_row_t d_cfg(input logic [CFG_W-1:0] v);
    return '{1'b1, v, '0, 1'b0, '0};
  endfunction

  function automatic dir_row_t d_ld(input int a, input int b, input logic [EW-1:0] wt);
    return '{1'b0, '0, '{OP_LOAD, NODE_W'(a), NODE_W'(b), wt}, 1'b0, '0};
  endfunction

  function automatic dir_row_t d_run(input bit lit, input logic st);
    return '{1'b0, '0, '{OP_RUN, '0, '0, '0}, lit, '{'0, '0, '0, '0, st, 1'b1, 1'b1}};
  endfunction

  // Only while the core is idle: drop valid, drain results, let the wipe finish.
  task automatic set_nodes(input logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tree_expect.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    nodes_cfg = v;
  endtask

  task automatic send_word(input in_t w, input bit lit, input out_t want);
    int gap, cnt, k;
    gap = tx_fast ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    cnt = mst_step(w);
    if (lit) begin
      tree_expect = {tree_expect, want};
    end else begin
      for (k = 0; k < cnt; k++) tree_expect = {tree_expect, step_res[k]};
    end
  endtask

  // result side
  initial begin
    int gap, rx_n;
    bit rx_fast;
    out_t got, want;
    out_ready = 1'b0;
    rx_n = 0;
    rx_fast = 1'b0;
    gap = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_n % 16 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      rx_n++;
      if (tree_expect.size() == 0) begin
        log_mismatch($sformatf("word with nothing pending: %h", got));
      end else begin
        want = tree_expect.pop_front();
        cmp_field("parent_node", 32'(got.parent_node), 32'(want.parent_node));
        cmp_field("child_node",  32'(got.child_node),  32'(want.child_node));
        cmp_field("edge_weight", 32'(got.edge_weight), 32'(want.edge_weight));
        cmp_field("total_cost",  32'(got.total_cost),  32'(want.total_cost));
        cmp_field("status",      32'(got.status),      32'(want.status));
        cmp_field("is_summary",  32'(got.is_summary),  32'(want.is_summary));
        cmp_field("last",        32'(got.last),        32'(want.last));
      end
      gap = rx_fast ? 0 : $urandom_range(0, 3);
      // long back-pressure mid-run so the core backs up onto its input
      if (hold_req && !held && got.last === 1'b0) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
    end
  end

  // stimulus side
  initial begin
    dir_row_t dir_q [$];
    dir_row_t row;
    int i, j, k, n, sel, useful, phase, extras, noise;
    bit keep_n, link;
    logic [CFG_W-1:0] nv;
    in_t w;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    err_cnt   = 0;
    tx_fast   = 1'b0;
    hold_req  = 1'b0;
    held      = 1'b0;
    nodes_cfg = CFG_W'(NUM_NODES_RST);
    for (i = 0; i < MAXN; i++) begin
      for (j = 0; j < MAXN; j++) adj[i][j] = NO_LINK;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty matrix at reset width: node 0 alone, so disconnected
    dir_q = {dir_q, d_run(1'b1, ST_SPLIT)};
    // one node: summary only, spanned
    dir_q = {dir_q, d_cfg(1)};
    dir_q = {dir_q, d_ld(0, 1, 5)};
    dir_q = {dir_q, d_run(1'b1, ST_SPANNED)};
    // zero count acts as one node
    dir_q = {dir_q, d_cfg(0)};
    dir_q = {dir_q, d_run(1'b1, ST_SPANNED)};
    // count above the max clamps; parallel edge, self-loop, zero weight
    dir_q = {dir_q, d_cfg(63)};
    dir_q = {dir_q, d_ld(0, 31, 16'hffff)};
    dir_q = {dir_q, d_ld(31, 0, 1)};
    dir_q = {dir_q, d_ld(5, 5, 7)};
    dir_q = {dir_q, d_ld(3, 4, 0)};
    dir_q = {dir_q, d_run(1'b0, ST_SPLIT)};
    // two nodes, max weight, endpoint out of range
    dir_q = {dir_q, d_cfg(2)};
    dir_q = {dir_q, d_ld(0, 1, 16'hffff)};
    dir_q = {dir_q, d_ld(1, 31, 3)};
    dir_q = {dir_q, d_run(1'b0, ST_SPANNED)};
    // equal weights: lowest index wins
    dir_q = {dir_q, d_cfg(4)};
    dir_q = {dir_q, d_ld(0, 1, 10)};
    dir_q = {dir_q, d_ld(1, 2, 10)};
    dir_q = {dir_q, d_ld(2, 3, 10)};
    dir_q = {dir_q, d_ld(3, 0, 10)};
    dir_q = {dir_q, d_ld(0, 2, 11)};
    dir_q = {dir_q, d_ld(3, 1, 16'hffff)};
    dir_q = {dir_q, d_run(1'b0, ST_SPANNED)};
    // full width, heavy edges around node 31, rest unreachable
    dir_q = {dir_q, d_cfg(32)};
    dir_q = {dir_q, d_ld(31, 30, 16'hffff)};
    dir_q = {dir_q, d_ld(0, 31, 16'hffff)};
    dir_q = {dir_q, d_run(1'b0, ST_SPLIT)};

    useful = 0;
    foreach (dir_q[k]) begin
      row = dir_q[k];
      if (row.set_cfg) begin
        set_nodes(row.cfg_val);
      end else begin
        send_word(row.word, row.lit, row.want);
        useful++;
      end
    end

    phase = 0;
    keep_n = 1'b0;
    while (useful < ITEM_TARGET) begin
      phase++;
      if (!keep_n) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) nv = CFG_W'($urandom_range(32, 63));
        else if (sel < 14) nv = CFG_W'($urandom_range(0, 1));
        else if (sel < 24) nv = CFG_W'($urandom_range(9, 31));
        else nv = CFG_W'($urandom_range(2, 8));
        set_nodes(nv);
      end
      keep_n = 1'b0;
      n = eff_nodes(nodes_cfg);
      tx_fast = ($urandom_range(0, 3) == 0);
      link = ($urandom_range(0, 6) != 0);
      // a random spanning tree, usually complete, then extra edges
      for (k = 1; k < n; k++) begin
        if (link || $urandom_range(0, 2) != 0) begin
          send_word(load_word(k, $urandom_range(0, k - 1), rand_weight()), 1'b0, '0);
          useful++;
        end
      end
      extras = $urandom_range(0, n / 2);
      for (k = 0; k < extras; k++) begin
        send_word(load_word($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                            rand_weight()), 1'b0, '0);
        useful++;
      end
      noise = $urandom_range(0, 2);
      for (k = 0; k < noise; k++) begin
        w = load_word($urandom_range(0, 31), $urandom_range(0, 31),
                      EW'($urandom_range(0, 65535)));
        sel = $urandom_range(0, 2);
        if (sel == 0) w.node_b = w.node_a;
        else if (sel == 1) w.weight = '0;
        send_word(w, 1'b0, '0);
      end
      // some phases end without a run so edges carry into the next count
      if ($urandom_range(0, 9) != 0) begin
        if (phase >= 5 && !held && n >= 3 && link) begin
          keep_n = 1'b1;
          hold_req = 1'b1;
        end
        send_word(run_word(), 1'b0, '0);
        useful++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tree_expect.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
